/* hw/rtl/bale_pkg.sv */
// Package for the bounded array list engine: parameters, codes and state types.
`timescale 1ns / 1ps
`default_nettype none

package bale_pkg;

   // Built number of list slots.
   localparam int CAPACITY_DEF = 8;

   // Width of the capacity_in_use register and its reset value.
   localparam int          CAP_REG_W   = 4;
   localparam logic [3:0]  CAP_RESET   = 4'd8;

   // Word address bit that selects a configuration register.
   localparam logic        REG_CAPACITY_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      CMD_APPEND    = 3'd0,
      CMD_INSERT    = 3'd1,
      CMD_DEL_SHIFT = 3'd2,
      CMD_DEL_SWAP  = 3'd3,
      CMD_READ      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MOVE,
      ST_PLACE
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/bale_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/bounded_array_list_engine.sv */
// Top level of the bounded array list engine: sequencer, count and configuration register.
`timescale 1ns / 1ps
`default_nettype none

// A packed list of up to CAPACITY 32-bit words kept in one RAM, plus a word count.
// An item (req_cmd, req_position, req_value) is taken at a rising edge where start
// is high and busy is low. Exactly one result per item appears on the rsp_ ports
// for one cycle, marked by rsp_strobe, in the cycle after the item's last step.
// The receiver cannot stall; results are never held back.
// Append, any error, insert at the end and delete of the last word finish on acceptance.
// Read and delete with swap pass through the fetch and move states once.
// Insert at position p below the count n moves each word from n-1 down to p up one
// slot, then writes the new word in the place state; delete with shift at position p
// below n-1 moves each word from p+1 to n-1 down one slot.
// Each moved word costs one read and one write of the single RAM, whose read
// data is registered, so each word moved takes a fetch step and a move step.
// The next item may be accepted in the same cycle its predecessor's result shows.
// capacity_in_use is to be written over the APB port while the block is idle, which the
// block itself does not enforce. Reset clears the word count and sets capacity_in_use to 8;
// the RAM contents are not cleared, since only words below the count are ever read.

module bounded_array_list_engine
   import bale_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [3:0]  req_position,
   input  wire logic [31:0] req_value,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_count,
   output logic [31:0]      rsp_read_value,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;

   state_type             state_ff, state_in;
   cmd_type               op_ff, op_in;
   logic [CW-1:0]         held_ff, held_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [31:0]           val_ff, val_in;
   logic [CAP_REG_W-1:0]  cap_ff;

   logic                  rsp_strobe_ff;
   status_type            rsp_status_ff;
   logic [3:0]            rsp_count_ff;
   logic [31:0]           rsp_read_value_ff;

   logic                  done;
   status_type            status;
   logic [31:0]           read_word;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [31:0]           ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [31:0]           ram_rdata;

   logic                  accept;
   logic [CMPW-1:0]       pos_c, held_c, lim_c, cap_c, held_in_c;
   logic [CW-1:0]         pos_n, held_m1, idx_up, idx_dn;
   logic                  full;
   logic                  cfg_write;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);

   assign pos_c   = CMPW'(req_position);
   assign held_c  = CMPW'(held_ff);
   assign cap_c   = CMPW'(cap_ff);
   assign lim_c   = (cap_c < CMPW'(CAPACITY)) ? cap_c : CMPW'(CAPACITY);
   assign full    = (held_c >= lim_c);
   assign pos_n   = pos_c[CW-1:0];
   assign held_m1 = held_ff - CW'(1);
   assign idx_up  = idx_ff + CW'(1);
   assign idx_dn  = idx_ff - CW'(1);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      held_in   = held_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      done      = 1'b0;
      status    = STATUS_DONE;
      read_word = '0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in  = cmd_type'(req_cmd);
               pos_in = pos_n;
               val_in = req_value;
               unique case (cmd_type'(req_cmd))
                  CMD_APPEND: begin
                     done = 1'b1;
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = held_ff[AW-1:0];
                        ram_wdata = req_value;
                        held_in   = held_ff + CW'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (pos_c > held_c) begin
                        done   = 1'b1;
                        status = STATUS_RANGE;
                     end else if (full) begin
                        done   = 1'b1;
                        status = STATUS_FULL;
                     end else if (pos_c == held_c) begin
                        // Inserting at the end moves nothing.
                        done      = 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = pos_n[AW-1:0];
                        ram_wdata = req_value;
                        held_in   = held_ff + CW'(1);
                     end else begin
                        idx_in   = held_ff;
                        state_in = ST_FETCH;
                     end
                  end
                  CMD_DEL_SHIFT, CMD_DEL_SWAP: begin
                     if (pos_c >= held_c) begin
                        done   = 1'b1;
                        status = STATUS_RANGE;
                     end else if (pos_n == held_m1) begin
                        // Removing the last word only shortens the list.
                        done    = 1'b1;
                        held_in = held_m1;
                     end else begin
                        idx_in   = pos_n;
                        state_in = ST_FETCH;
                     end
                  end
                  CMD_READ: begin
                     if (pos_c >= held_c) begin
                        done   = 1'b1;
                        status = STATUS_RANGE;
                     end else begin
                        idx_in   = pos_n;
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     done   = 1'b1;
                     status = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            unique case (op_ff)
               CMD_INSERT:    ram_raddr = idx_dn[AW-1:0];
               CMD_DEL_SHIFT: ram_raddr = idx_up[AW-1:0];
               CMD_DEL_SWAP:  ram_raddr = held_m1[AW-1:0];
               default:       ram_raddr = idx_ff[AW-1:0];
            endcase
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            unique case (op_ff)
               CMD_READ: begin
                  done      = 1'b1;
                  read_word = ram_rdata;
                  state_in  = ST_IDLE;
               end
               CMD_DEL_SWAP: begin
                  ram_we    = 1'b1;
                  ram_waddr = pos_ff[AW-1:0];
                  held_in   = held_m1;
                  done      = 1'b1;
                  state_in  = ST_IDLE;
               end
               CMD_DEL_SHIFT: begin
                  ram_we = 1'b1;
                  idx_in = idx_up;
                  if (idx_up < held_m1) begin
                     state_in = ST_FETCH;
                  end else begin
                     held_in  = held_m1;
                     done     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               CMD_INSERT: begin
                  ram_we = 1'b1;
                  idx_in = idx_dn;
                  if (idx_dn > pos_ff) begin
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_PLACE;
                  end
               end
               default: begin
                  done     = 1'b1;
                  status   = STATUS_RANGE;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = val_ff;
            held_in   = held_ff + CW'(1);
            done      = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign held_in_c = CMPW'(held_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      if (done) begin
         rsp_status_ff     <= status;
         rsp_count_ff      <= held_in_c[3:0];
         rsp_read_value_ff <= read_word;
      end
   end

   bale_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Configuration register.
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (cfg_write) begin
         cap_ff <= pwdata[CAP_REG_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_CAPACITY_IN_USE) ? {{(32-CAP_REG_W){1'b0}}, cap_ff} : '0;
   assign pready = 1'b1;

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_read_value_ff;

   // The count never exceeds the built capacity.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(held_ff) <= CMPW'(CAPACITY))
      else $error("word count exceeds capacity");

   // The count moves by at most one word per cycle.
   a_held_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (held_ff == $past(held_ff)) || (held_ff == $past(held_ff) + CW'(1))
                        || (held_ff == $past(held_ff) - CW'(1)))
      else $error("word count jumped");

   // The RAM is only written while an item is being worked on.
   a_write_owned: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (accept || state_ff != ST_IDLE))
      else $error("RAM write outside an item");

   // A result always comes back with the sequencer idle again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("result shown while still busy");

   // Failed items never return a word.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_DONE) |-> (rsp_read_value == '0))
      else $error("failed item returned data");

endmodule

`default_nettype wire

/* test/tb_bounded_array_list_engine.sv */
// Self-checking testbench for the bounded array list engine, with its own list model.
`timescale 1ns / 1ps

module tb_bounded_array_list_engine;
   import bale_pkg::*;

   localparam int SLOTS         = CAPACITY_DEF;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [2:0] CAP_ADDR         = {REG_CAPACITY_IN_USE, 2'b00};
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      status_type  status;
      logic [3:0]  count;
      logic [31:0] read_value;
   } list_result_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_cmd;
   logic [3:0]  req_position;
   logic [31:0] req_value;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_count;
   logic [31:0] rsp_read_value;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Model of the list: words, count held and the capacity register.
   logic [31:0]  list_words [SLOTS];
   int           word_count;
   logic [3:0]   cap_setting;
   list_result_t pending_results [$];

   int mismatches;
   int cycles;
   int items_sent;
   int results_seen;
   int full_replies;
   int range_replies;
   int good_reads;
   int cap_writes;

   bounded_array_list_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycles, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Applies one list operation to the model and returns the result it should give.
   function automatic list_result_t apply_list_op(input logic [2:0] cmd,
                                                  input logic [3:0] pos,
                                                  input logic [31:0] val);
      list_result_t res;
      int lim;
      int i;
      res.status     = STATUS_DONE;
      res.read_value = 32'd0;
      lim = (int'(cap_setting) > SLOTS) ? SLOTS : int'(cap_setting);
      case (cmd)
         CMD_APPEND: begin
            if (word_count >= lim) begin
               res.status = STATUS_FULL;
            end else begin
               list_words[word_count] = val;
               word_count++;
            end
         end
         CMD_INSERT: begin
            // The position check wins over the full check.
            if (int'(pos) > word_count) begin
               res.status = STATUS_RANGE;
            end else if (word_count >= lim) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = word_count; i > int'(pos); i--)
                  list_words[i] = list_words[i - 1];
               list_words[pos] = val;
               word_count++;
            end
         end
         CMD_DEL_SHIFT: begin
            if (int'(pos) >= word_count) begin
               res.status = STATUS_RANGE;
            end else begin
               for (i = int'(pos); i + 1 < word_count; i++)
                  list_words[i] = list_words[i + 1];
               word_count--;
            end
         end
         CMD_DEL_SWAP: begin
            if (int'(pos) >= word_count) begin
               res.status = STATUS_RANGE;
            end else begin
               list_words[pos] = list_words[word_count - 1];
               word_count--;
            end
         end
         CMD_READ: begin
            if (int'(pos) >= word_count) begin
               res.status = STATUS_RANGE;
            end else begin
               res.read_value = list_words[pos];
               good_reads++;
            end
         end
         default: begin
            res.status = STATUS_RANGE;
         end
      endcase
      if (res.status == STATUS_FULL)
         full_replies++;
      if (res.status == STATUS_RANGE)
         range_replies++;
      res.count = 4'(word_count);
      return res;
   endfunction

   // Offers one item and waits until the block takes it. start is left high so that
   // a following item can go out back to back.
   task automatic send_item(input logic [2:0] cmd, input logic [3:0] pos,
                            input logic [31:0] val);
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_list_op(cmd, pos, val));
      items_sent++;
   endtask

   task automatic sender_gap(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes capacity_in_use with random upper bits, then reads it back.
   task automatic write_capacity(input logic [3:0] cap);
      logic [31:0] word;
      word = $urandom;
      word[CAP_REG_W-1:0] = cap;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAP_ADDR;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      cap_setting = cap;
      cap_writes++;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[CAP_REG_W-1:0] !== cap) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("Register read-back: expected %0d, got %0d", cap,
                     prdata[CAP_REG_W-1:0]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      list_result_t exp;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected result: status %0d count %0d value %h",
                        rsp_status, rsp_count, rsp_read_value);
         end else begin
            exp = pending_results.pop_front();
            if (rsp_status !== exp.status || rsp_count !== exp.count ||
                rsp_read_value !== exp.read_value) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Result %0d: expected status %0d count %0d value %h, got %0d %0d %h",
                           results_seen, exp.status, exp.count, exp.read_value,
                           rsp_status, rsp_count, rsp_read_value);
            end
         end
      end
   end

   // Every operation at the edges of the list, errors included, at full capacity.
   task automatic check_basic_operations();
      send_item(CMD_READ, 4'd0, 32'd0);
      send_item(CMD_DEL_SHIFT, 4'd0, 32'd0);
      send_item(CMD_APPEND, 4'd15, 32'h0000_0000);
      send_item(CMD_APPEND, 4'd0, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 4'd0, 32'hA5A5_A5A5);
      send_item(CMD_INSERT, 4'd4, 32'h1234_5678);
      send_item(CMD_INSERT, 4'd3, 32'h5A5A_5A5A);
      send_item(CMD_READ, 4'd1, 32'hFFFF_FFFF);
      send_item(CMD_READ, 4'd15, 32'd0);
      send_item(CMD_DEL_SHIFT, 4'd1, 32'd0);
      send_item(CMD_DEL_SWAP, 4'd0, 32'd0);
      send_item(CMD_UNUSED_FIRST, 4'd0, 32'hFFFF_FFFF);
      send_item(CMD_UNUSED_MID, 4'd1, 32'd0);
      send_item(CMD_UNUSED_LAST, 4'd15, 32'd0);
      while (word_count < SLOTS)
         send_item(CMD_APPEND, 4'd0, $urandom);
      send_item(CMD_APPEND, 4'd0, 32'hDEAD_BEEF);
      send_item(CMD_INSERT, 4'd0, 32'hDEAD_BEEF);
      // Position past the count reports range even though the list is full.
      send_item(CMD_INSERT, 4'd9, 32'hDEAD_BEEF);
      send_item(CMD_READ, 4'd7, 32'd0);
      send_item(CMD_DEL_SHIFT, 4'd7, 32'd0);
      send_item(CMD_DEL_SWAP, 4'd6, 32'd0);
      send_item(CMD_DEL_SWAP, 4'd0, 32'd0);
   endtask

   // Capacity below the words held, zero, and above the built size.
   task automatic check_capacity_edges();
      wait_drained();
      while (word_count < 6)
         send_item(CMD_APPEND, 4'd0, $urandom);
      wait_drained();
      write_capacity(4'd2);
      send_item(CMD_APPEND, 4'd0, $urandom);
      send_item(CMD_INSERT, 4'd0, $urandom);
      send_item(CMD_READ, 4'(word_count - 1), 32'd0);
      send_item(CMD_DEL_SWAP, 4'd0, 32'd0);
      wait_drained();
      write_capacity(4'd0);
      send_item(CMD_APPEND, 4'd0, $urandom);
      send_item(CMD_INSERT, 4'(word_count), $urandom);
      wait_drained();
      write_capacity(4'd15);
      while (word_count < SLOTS)
         send_item(CMD_APPEND, 4'd0, $urandom);
      send_item(CMD_APPEND, 4'd0, $urandom);
      send_item(CMD_INSERT, 4'd3, $urandom);
      wait_drained();
      write_capacity(CAP_RESET);
   endtask

   // Mostly in-range operations with random words, some bad positions and unused codes.
   task automatic run_random_phases();
      logic [3:0]  phase_cap [6];
      int          phase_idle [6];
      int          phase_items [6];
      logic [2:0]  cmd;
      logic [3:0]  pos;
      logic [31:0] val;
      int          pick;
      phase_cap   = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8};
      phase_idle  = '{0, 54, 29, 54, 0, 29};
      phase_items = '{150, 150, 150, 60, 170, 170};
      phase_cap[5] = 4'($urandom_range(15));
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_capacity(phase_cap[ph]);
         for (int n = 0; n < phase_items[ph]; n++) begin
            pick = $urandom_range(99);
            if (pick < 5)
               cmd = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
            else if (pick < 30)
               cmd = CMD_APPEND;
            else if (pick < 50)
               cmd = CMD_INSERT;
            else if (pick < 65)
               cmd = CMD_DEL_SHIFT;
            else if (pick < 80)
               cmd = CMD_DEL_SWAP;
            else
               cmd = CMD_READ;
            if ($urandom_range(9) == 0)
               pos = 4'($urandom_range(15));
            else if (cmd == CMD_INSERT)
               pos = 4'($urandom_range(word_count));
            else
               pos = 4'($urandom_range(word_count > 0 ? word_count - 1 : 0));
            pick = $urandom_range(15);
            if (pick == 0)
               val = 32'h0000_0000;
            else if (pick == 1)
               val = 32'hFFFF_FFFF;
            else
               val = $urandom;
            send_item(cmd, pos, val);
            sender_gap(phase_idle[ph]);
            if ($urandom_range(63) == 0)
               wait_drained();
         end
      end
   endtask

   initial begin
      mismatches    = 0;
      cycles        = 0;
      items_sent    = 0;
      results_seen  = 0;
      full_replies  = 0;
      range_replies = 0;
      good_reads    = 0;
      cap_writes    = 0;
      word_count    = 0;
      cap_setting   = CAP_RESET;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_cmd       <= CMD_APPEND;
      req_position  <= 4'd0;
      req_value     <= 32'd0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= CAP_ADDR;
      pwdata        <= 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_basic_operations();
      check_capacity_edges();
      run_random_phases();
      wait_drained();
      $display("Sent %0d items and checked %0d results over %0d capacity writes;",
               items_sent, results_seen, cap_writes);
      $display("%0d full replies, %0d out-of-range replies, %0d successful reads.",
               full_replies, range_replies, good_reads);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches,
                  pending_results.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/bale_pkg.sv
hw/rtl/bale_ram.sv
hw/rtl/bounded_array_list_engine.sv
test/tb_bounded_array_list_engine.sv
